@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the RTL; they compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// Shell sort package
// Sizes, record and beat types, and sequencer states for the sort block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int KEY_BITS    = 48;
   localparam int TAG_BITS    = 16;

   localparam int IDX_BITS = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_BITS = $clog2(MAX_RECORDS + 1);
   localparam int REC_BITS = KEY_BITS + TAG_BITS;

   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_RECORDS);

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } rec_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
      logic                final_record;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] sorted_key;
      logic [TAG_BITS-1:0] sorted_tag;
      logic                last_out;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      rec_type             wr_data;
      logic [IDX_BITS-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic overflow;
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_READ,
      ST_LOAD,
      ST_CMP,
      ST_PUT,
      ST_EMIT
   } seq_state_type;

endpackage

`default_nettype wire

@@ src/ssd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/ssd_seq.sv @@
// ----------------------------------------------------------------------------
// Shell sort sequencer
// Loads records, runs the gapped insertion passes through one key comparator
// and streams the sorted store out.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire ssd_pkg::req_type     req_data,
   output      logic                 busy,
   output      ssd_pkg::mem_req_type mem_req,
   input  wire ssd_pkg::rec_type     rd_data,
   output      ssd_pkg::emit_type    emit
);

   ssd_pkg::seq_state_type state_ff, state_in;
   logic [ssd_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic [ssd_pkg::CNT_BITS-1:0] gap_ff, gap_in;
   logic [ssd_pkg::CNT_BITS-1:0] i_ff, i_in;
   logic [ssd_pkg::CNT_BITS-1:0] j_ff, j_in;
   logic [ssd_pkg::CNT_BITS-1:0] e_ff, e_in;
   ssd_pkg::rec_type             k_ff, k_in;
   ssd_pkg::emit_type            emit_ff, emit_in;

   logic [ssd_pkg::CNT_BITS-1:0] i_inc;
   logic [ssd_pkg::CNT_BITS-1:0] nj;
   logic [ssd_pkg::CNT_BITS-1:0] cnt_inc;
   logic                         key_greater;

   // The single shared comparator of the sort.
   assign key_greater = k_ff.key > rd_data.key;
   assign i_inc       = i_ff + 1'b1;
   assign nj          = j_ff - gap_ff;
   assign cnt_inc     = count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssd_pkg::ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      e_ff   <= e_in;
      k_ff   <= k_in;
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      gap_in          = gap_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      e_in            = e_ff;
      k_in            = k_ff;
      emit_in         = '0;
      mem_req         = '0;
      busy            = 1'b1;

      case (state_ff)
         ssd_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (count_ff < ssd_pkg::MAX_CNT) begin
                  mem_req.wr_en       = 1'b1;
                  mem_req.wr_addr     = count_ff[ssd_pkg::IDX_BITS-1:0];
                  mem_req.wr_data.key = req_data.key;
                  mem_req.wr_data.tag = req_data.tag;
                  count_in            = cnt_inc;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.final_record) begin
                  gap_in   = ((count_ff < ssd_pkg::MAX_CNT) ? cnt_inc : count_ff) >> 1;
                  state_in = ssd_pkg::ST_GAP;
               end
            end
         end
         ssd_pkg::ST_GAP: begin
            if (gap_ff == '0) begin
               e_in     = '0;
               state_in = ssd_pkg::ST_EMIT;
            end else begin
               i_in     = gap_ff;
               state_in = ssd_pkg::ST_READ;
            end
         end
         ssd_pkg::ST_READ: begin
            mem_req.rd_addr = i_ff[ssd_pkg::IDX_BITS-1:0];
            state_in        = ssd_pkg::ST_LOAD;
         end
         ssd_pkg::ST_LOAD: begin
            k_in            = rd_data;
            j_in            = i_ff;
            mem_req.rd_addr = 
               ssd_pkg::IDX_BITS'(i_ff - gap_ff);
            state_in        = ssd_pkg::ST_CMP;
         end
         ssd_pkg::ST_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff[ssd_pkg::IDX_BITS-1:0];
            if (key_greater) begin
               // Shift the compared record up one gap and read the one a gap further down.
               mem_req.wr_data = rd_data;
               j_in            = nj;
               if (nj >= gap_ff) begin
                  mem_req.rd_addr = ssd_pkg::IDX_BITS'(nj - gap_ff);
               end else begin
                  state_in = ssd_pkg::ST_PUT;
               end
            end else begin
               mem_req.wr_data = k_ff;
               i_in            = i_inc;
               if (i_inc < count_ff) begin
                  state_in = ssd_pkg::ST_READ;
               end else begin
                  gap_in   = gap_ff >> 1;
                  state_in = ssd_pkg::ST_GAP;
               end
            end
         end
         ssd_pkg::ST_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff[ssd_pkg::IDX_BITS-1:0];
            mem_req.wr_data = k_ff;
            i_in            = i_inc;
            if (i_inc < count_ff) begin
               state_in = ssd_pkg::ST_READ;
            end else begin
               gap_in   = gap_ff >> 1;
               state_in = ssd_pkg::ST_GAP;
            end
         end
         ssd_pkg::ST_EMIT: begin
            mem_req.rd_addr  = e_ff[ssd_pkg::IDX_BITS-1:0];
            emit_in.valid    = 1'b1;
            emit_in.last     = (e_ff + 1'b1) == count_ff;
            emit_in.overflow = ovf_ff;
            e_in             = e_ff + 1'b1;
            if ((e_ff + 1'b1) == count_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ssd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssd_pkg::ST_IDLE;
         end
      endcase
   end

   assign emit = emit_ff;

endmodule

`default_nettype wire

@@ src/shell_sort_descending.sv @@
// ----------------------------------------------------------------------------
// Shell sort, descending
// Collects tagged records and returns them sorted by key, largest first.
// ----------------------------------------------------------------------------
// Loading takes one beat per cycle; busy stays low until the final record.
// Sorting: each gap is checked in ST_GAP; an insertion step fetches its record in
// ST_READ and ST_LOAD, shifts in ST_CMP and places it in ST_CMP or ST_PUT.
// Emission: n beats back to back, the first after the final gap check, ST_EMIT and
// the store read register; busy drops with the last.
// Synchronous reset empties the set and clears overflow; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shell_sort_descending (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire ssd_pkg::req_type req_data,
   output      logic             busy,
   output      logic             rsp_valid,
   output      ssd_pkg::rsp_type rsp_data
);

   // Memory requests from the sequencer and the registered read word.
   ssd_pkg::mem_req_type          mem_req;
   logic [ssd_pkg::REC_BITS-1:0]  rd_word;
   ssd_pkg::rec_type              rd_rec;
   ssd_pkg::emit_type             emit;

   assign rd_rec = ssd_pkg::rec_type'(rd_word);

   // The sequencer does all loading, the gapped insertion passes and the
   // read-out; its emit flags are registered in step with the read data.
   ssd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .mem_req  (mem_req),
      .rd_data  (rd_rec),
      .emit     (emit)
   );

   // Record store: key and tag side by side in one word.
   ssd_ram #(
      .WIDTH (ssd_pkg::REC_BITS),
      .DEPTH (ssd_pkg::MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_word)
   );

   // Each result beat comes straight off the store's read register.
   assign rsp_valid           = emit.valid;
   assign rsp_data.sorted_key = rd_rec.key;
   assign rsp_data.sorted_tag = rd_rec.tag;
   assign rsp_data.last_out   = emit.valid & emit.last;
   assign rsp_data.overflow   = emit.valid & emit.overflow;

   // A final record always starts a sort.
   `ASSERT_NEXT(a_final_busy, clock, reset, start && !busy && req_data.final_record, busy)
   // The last beat of a run is never followed directly by another beat.
   `ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_data.last_out, !rsp_valid)
   // Mid-run beats only appear while the block is still reading out.
   `ASSERT_SAME(a_mid_busy, clock, reset, rsp_valid && !rsp_data.last_out, busy)
   // Keys within a run never increase.
   `ASSERT_SAME(a_desc, clock, reset, rsp_valid && $past(rsp_valid && !rsp_data.last_out),
                rsp_data.sorted_key <= $past(rsp_data.sorted_key))

endmodule

`default_nettype wire
